@@ sv/plic_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plic_pkg
// Shared widths, command codes and address map of the platform interrupt
// controller.
// ----------------------------------------------------------------------------
package plic_pkg;

   localparam int DEF_NUM_HARTS   = 4;
   localparam int DEF_NUM_SOURCES = 32;

   localparam int CMD_W    = 2;
   localparam int OFFSET_W = 26;
   localparam int DATA_W   = 32;
   localparam int SRC_W    = 5;
   localparam int PRIO_W   = 3;
   localparam int HARTS_W  = 3;
   localparam int LINE_W   = 4;
   localparam int WORD_W   = 10;

   localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LEVEL = 2'd2;

   localparam logic [OFFSET_W-1:0] PEND_BASE = 26'h000_1000;
   localparam logic [OFFSET_W-1:0] EN_BASE   = 26'h000_2000;
   localparam logic [OFFSET_W-1:0] CTX_BASE  = 26'h020_0000;
   localparam int EN_STRIDE  = 'h80;
   localparam int CTX_STRIDE = 'h1000;
   localparam int EN_CTX_LSB = 7;

   localparam logic [WORD_W-1:0] CTX_WORD_THRESHOLD = 10'd0;
   localparam logic [WORD_W-1:0] CTX_WORD_CLAIM     = 10'd1;

   localparam logic [HARTS_W-1:0] ACTIVE_HARTS_RESET = 3'd1;

endpackage

@@ sv/platform_interrupt_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// platform_interrupt_controller
// Interrupt controller with pending, claimed, priority and per-hart enable
// state, driven by word bus accesses and source level changes.
//
//   Channel   Ports                 Handshake
//   request   start, busy, req_*    accepted when start is high, busy low
//   response  rsp_strobe, rsp_*     one cycle per transaction, no stall
//   config    csr_write_*           written when csr_write_enable is high
//
// A transaction is taken in every cycle; busy is always low.
// Its response passes through the input register, then decode, claim encode
// and line update into the response register, where the state update of the
// same cycle also lands.
// Reset is synchronous and clears interrupt state; active_harts resets to one.
// The receiver cannot stall, so nothing ever holds a transaction back.
// ----------------------------------------------------------------------------
module platform_interrupt_controller #(
   parameter int NUM_HARTS   = plic_pkg::DEF_NUM_HARTS,
   parameter int NUM_SOURCES = plic_pkg::DEF_NUM_SOURCES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [plic_pkg::CMD_W-1:0]       req_command,
   input  logic [plic_pkg::OFFSET_W-1:0]    req_offset,
   input  logic [plic_pkg::DATA_W-1:0]      req_write_data,
   input  logic [plic_pkg::SRC_W-1:0]       req_irq_source,
   input  logic                             req_irq_level,
   output logic                             rsp_strobe,
   output logic [plic_pkg::DATA_W-1:0]      rsp_read_data,
   output logic                             rsp_access_error,
   output logic [plic_pkg::LINE_W-1:0]      rsp_supervisor_lines,
   output logic [plic_pkg::LINE_W-1:0]      rsp_machine_lines,
   input  logic                             csr_write_enable,
   input  logic [plic_pkg::HARTS_W-1:0]     csr_write_data
);
   import plic_pkg::*;

   localparam int NUM_CTX   = 2 * NUM_HARTS;
   localparam int SRC_IDX_W = $clog2(NUM_SOURCES);
   localparam int CTX_W     = $clog2(NUM_CTX);

   localparam logic [OFFSET_W-1:0] PRIO_END = OFFSET_W'(4 * NUM_SOURCES);
   localparam logic [OFFSET_W-1:0] PEND_END = PEND_BASE + OFFSET_W'(NUM_SOURCES / 8);
   localparam logic [OFFSET_W-1:0] EN_END   = EN_BASE + OFFSET_W'(EN_STRIDE * NUM_CTX);
   localparam logic [OFFSET_W-1:0] CTX_END  = CTX_BASE + OFFSET_W'(CTX_STRIDE * NUM_CTX);

   logic                   req_valid_ff;
   logic [CMD_W-1:0]       req_command_ff;
   logic [OFFSET_W-1:0]    req_offset_ff;
   logic [DATA_W-1:0]      req_write_data_ff;
   logic [SRC_W-1:0]       req_irq_source_ff;
   logic                   req_irq_level_ff;

   logic [HARTS_W-1:0]     active_harts_ff;
   logic [HARTS_W-1:0]     harts_present;

   logic [NUM_SOURCES-1:0] pending_ff, pending_in;
   logic [NUM_SOURCES-1:0] claimed_ff, claimed_in;
   logic [PRIO_W-1:0]      prio_ff [NUM_SOURCES];
   logic [PRIO_W-1:0]      prio_in [NUM_SOURCES];
   logic [DATA_W-1:0]      enable_ff [NUM_CTX];
   logic [DATA_W-1:0]      enable_in [NUM_CTX];

   logic                   rsp_strobe_ff;
   logic [DATA_W-1:0]      rsp_read_data_ff, rsp_read_data_in;
   logic                   rsp_access_error_ff, rsp_access_error_in;
   logic [LINE_W-1:0]      rsp_sup_ff, rsp_sup_in;
   logic [LINE_W-1:0]      rsp_mach_ff, rsp_mach_in;

   logic                   is_write;
   logic [SRC_IDX_W-1:0]   prio_idx;
   logic [CTX_W-1:0]       en_ctx;
   logic [HARTS_W-1:0]     en_hart;
   logic [WORD_W-1:0]      ctx_word;
   logic [NUM_SOURCES-1:0] eligible;
   logic [NUM_SOURCES-1:0] eligible_in;
   logic [SRC_IDX_W-1:0]   claim_idx;

   assign busy = 1'b0;

   assign harts_present = (active_harts_ff > HARTS_W'(NUM_HARTS)) ?
                          HARTS_W'(NUM_HARTS) : active_harts_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff    <= 1'b0;
         active_harts_ff <= ACTIVE_HARTS_RESET;
      end else begin
         req_valid_ff <= start & ~busy;
         if (csr_write_enable) begin
            active_harts_ff <= csr_write_data;
         end
      end
      if (start && !busy) begin
         req_command_ff    <= req_command;
         req_offset_ff     <= req_offset;
         req_write_data_ff <= req_write_data;
         req_irq_source_ff <= req_irq_source;
         req_irq_level_ff  <= req_irq_level;
      end
   end

   always_comb begin
      is_write  = (req_command_ff == CMD_WRITE);
      prio_idx  = req_offset_ff[2 +: SRC_IDX_W];
      en_ctx    = req_offset_ff[EN_CTX_LSB +: CTX_W];
      en_hart   = HARTS_W'(en_ctx) >> 1;
      ctx_word  = req_offset_ff[2 +: WORD_W];
      eligible  = pending_ff & ~claimed_ff;
      claim_idx = '0;
      for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
         if (eligible[i]) begin
            claim_idx = SRC_IDX_W'(i);
         end
      end

      pending_in          = pending_ff;
      claimed_in          = claimed_ff;
      prio_in             = prio_ff;
      enable_in           = enable_ff;
      rsp_read_data_in    = '0;
      rsp_access_error_in = 1'b0;

      if (req_valid_ff) begin
         case (req_command_ff)
            CMD_LEVEL: begin
               for (int i = 1; i < NUM_SOURCES; i++) begin
                  if (req_irq_source_ff == SRC_W'(i)) begin
                     pending_in[i] = req_irq_level_ff;
                  end
               end
            end
            CMD_READ, CMD_WRITE: begin
               if (req_offset_ff < PRIO_END) begin
                  if (is_write) begin
                     prio_in[prio_idx] = req_write_data_ff[PRIO_W-1:0];
                  end else begin
                     rsp_read_data_in = DATA_W'(prio_ff[prio_idx]);
                  end
               end else if (req_offset_ff >= PEND_BASE && req_offset_ff < PEND_END) begin
                  if (is_write) begin
                     rsp_access_error_in = 1'b1;
                  end else if (req_offset_ff == PEND_BASE) begin
                     rsp_read_data_in = DATA_W'(pending_ff);
                  end
               end else if (req_offset_ff >= EN_BASE && req_offset_ff < EN_END) begin
                  if (en_hart < harts_present) begin
                     if (is_write) begin
                        enable_in[en_ctx] = req_write_data_ff;
                     end else begin
                        rsp_read_data_in = enable_ff[en_ctx];
                     end
                  end
               end else if (req_offset_ff >= CTX_BASE && req_offset_ff < CTX_END) begin
                  if (ctx_word == CTX_WORD_THRESHOLD) begin
                     if (is_write) begin
                        prio_in[0] = req_write_data_ff[PRIO_W-1:0];
                     end
                  end else if (ctx_word == CTX_WORD_CLAIM) begin
                     if (is_write) begin
                        for (int i = 0; i < NUM_SOURCES; i++) begin
                           if (req_write_data_ff[SRC_W-1:0] == SRC_W'(i)) begin
                              claimed_in[i] = 1'b0;
                           end
                        end
                     end else if (|eligible) begin
                        claimed_in[claim_idx] = 1'b1;
                        pending_in[claim_idx] = 1'b0;
                        rsp_read_data_in      = DATA_W'(claim_idx);
                     end
                  end else if (is_write) begin
                     rsp_access_error_in = 1'b1;
                  end
               end else begin
                  rsp_access_error_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      eligible_in = pending_in & ~claimed_in;
      rsp_sup_in  = '0;
      rsp_mach_in = '0;
      for (int h = 0; h < NUM_HARTS; h++) begin
         if (HARTS_W'(h) < harts_present) begin
            rsp_sup_in[h]  = |(eligible_in & enable_in[2*h][NUM_SOURCES-1:0]);
            rsp_mach_in[h] = |(eligible_in & enable_in[2*h+1][NUM_SOURCES-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
         pending_ff    <= '0;
         claimed_ff    <= '0;
         for (int i = 0; i < NUM_SOURCES; i++) begin
            prio_ff[i] <= '0;
         end
         for (int c = 0; c < NUM_CTX; c++) begin
            enable_ff[c] <= '0;
         end
      end else begin
         rsp_strobe_ff <= req_valid_ff;
         pending_ff    <= pending_in;
         claimed_ff    <= claimed_in;
         prio_ff       <= prio_in;
         enable_ff     <= enable_in;
      end
      rsp_read_data_ff    <= rsp_read_data_in;
      rsp_access_error_ff <= rsp_access_error_in;
      rsp_sup_ff          <= rsp_sup_in;
      rsp_mach_ff         <= rsp_mach_in;
   end

   assign rsp_strobe           = rsp_strobe_ff;
   assign rsp_read_data        = rsp_read_data_ff;
   assign rsp_access_error     = rsp_access_error_ff;
   assign rsp_supervisor_lines = rsp_sup_ff;
   assign rsp_machine_lines    = rsp_mach_ff;

   // Every accepted transaction yields a response strobe.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("accepted transaction produced no response");

   // Source zero is reserved and can never become pending.
   assert property (@(posedge clock) disable iff (reset)
      !pending_ff[0])
      else $error("reserved source zero is pending");

   // An errored access never returns data.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_access_error) |-> (rsp_read_data == '0))
      else $error("access error with nonzero read data");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the platform interrupt controller. A behavioral
// model of the pending, claimed, priority and enable state predicts every
// response. Directed tests cover priority and threshold access, claim and
// complete, access errors and the hart limit. Random traffic then runs under
// several active hart settings and sender idle rates.
// ----------------------------------------------------------------------------
module testbench;
   import plic_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [OFFSET_W-1:0] offset;
      logic [DATA_W-1:0]   write_data;
      logic [SRC_W-1:0]    irq_source;
      logic                irq_level;
   } request_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              access_error;
      logic [LINE_W-1:0] supervisor_lines;
      logic [LINE_W-1:0] machine_lines;
   } response_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [CMD_W-1:0]    req_command = CMD_READ;
   logic [OFFSET_W-1:0] req_offset = '0;
   logic [DATA_W-1:0]   req_write_data = '0;
   logic [SRC_W-1:0]    req_irq_source = '0;
   logic                req_irq_level = 1'b0;
   logic                rsp_strobe;
   logic [DATA_W-1:0]   rsp_read_data;
   logic                rsp_access_error;
   logic [LINE_W-1:0]   rsp_supervisor_lines;
   logic [LINE_W-1:0]   rsp_machine_lines;
   logic                csr_write_enable = 1'b0;
   logic [HARTS_W-1:0]  csr_write_data = '0;

   logic [DATA_W-1:0]  pending_mask = '0;
   logic [DATA_W-1:0]  claimed_mask = '0;
   logic [PRIO_W-1:0]  source_priority [DEF_NUM_SOURCES] = '{default: '0};
   logic [DATA_W-1:0]  enable_masks [2*DEF_NUM_HARTS] = '{default: '0};
   logic [HARTS_W-1:0] active_harts = ACTIVE_HARTS_RESET;

   response_type expected_responses [$];
   int           failures = 0;
   int           sender_idle_pct = 0;

   platform_interrupt_controller DUT (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_command          (req_command),
      .req_offset           (req_offset),
      .req_write_data       (req_write_data),
      .req_irq_source       (req_irq_source),
      .req_irq_level        (req_irq_level),
      .rsp_strobe           (rsp_strobe),
      .rsp_read_data        (rsp_read_data),
      .rsp_access_error     (rsp_access_error),
      .rsp_supervisor_lines (rsp_supervisor_lines),
      .rsp_machine_lines    (rsp_machine_lines),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data)
   );

   always #5 clock = ~clock;

   initial begin
      #(5_000_000);
      $display("tb: failure");
      $finish;
   end

   function automatic response_type predict_response(input request_type rq);
      response_type rs;
      logic [31:0]  ready;
      int unsigned  off, ctx, word, harts;
      bit           wr;
      rs = '0;
      off = 32'(rq.offset);
      wr = (rq.command == CMD_WRITE);
      harts = (active_harts > DEF_NUM_HARTS) ? DEF_NUM_HARTS : 32'(active_harts);
      if (rq.command == CMD_LEVEL) begin
         if (rq.irq_source != 0 && rq.irq_source < DEF_NUM_SOURCES)
            pending_mask[rq.irq_source] = rq.irq_level;
      end else if (rq.command == CMD_READ || rq.command == CMD_WRITE) begin
         if (off < 4 * DEF_NUM_SOURCES) begin
            if (wr)
               source_priority[off >> 2] = rq.write_data[PRIO_W-1:0];
            else
               rs.read_data = DATA_W'(source_priority[off >> 2]);
         end else if (off >= PEND_BASE && off < PEND_BASE + DEF_NUM_SOURCES / 8) begin
            if (wr)
               rs.access_error = 1'b1;
            else if (off == PEND_BASE)
               rs.read_data = pending_mask;
         end else if (off >= EN_BASE && off < EN_BASE + EN_STRIDE * 2 * DEF_NUM_HARTS) begin
            ctx = (off - EN_BASE) >> EN_CTX_LSB;
            if ((ctx >> 1) < harts) begin
               if (wr)
                  enable_masks[ctx] = rq.write_data;
               else
                  rs.read_data = enable_masks[ctx];
            end
         end else if (off >= CTX_BASE && off < CTX_BASE + CTX_STRIDE * 2 * DEF_NUM_HARTS) begin
            word = (off % CTX_STRIDE) >> 2;
            if (word == CTX_WORD_THRESHOLD) begin
               if (wr)
                  source_priority[0] = rq.write_data[PRIO_W-1:0];
            end else if (word == CTX_WORD_CLAIM) begin
               if (wr) begin
                  claimed_mask[rq.write_data[SRC_W-1:0]] = 1'b0;
               end else begin
                  ready = pending_mask & ~claimed_mask;
                  for (int i = 0; i < 32; i++) begin
                     if (ready[i]) begin
                        claimed_mask[i] = 1'b1;
                        pending_mask[i] = 1'b0;
                        rs.read_data = DATA_W'(i);
                        break;
                     end
                  end
               end
            end else if (wr) begin
               rs.access_error = 1'b1;
            end
         end else begin
            rs.access_error = 1'b1;
         end
      end
      ready = pending_mask & ~claimed_mask;
      for (int h = 0; h < harts; h++) begin
         rs.supervisor_lines[h] = |(ready & enable_masks[2*h]);
         rs.machine_lines[h] = |(ready & enable_masks[2*h+1]);
      end
      return rs;
   endfunction

   always @(posedge clock) begin
      response_type want;
      if (!reset && rsp_strobe) begin
         if (expected_responses.size() == 0) begin
            $error("response with no transaction outstanding");
            failures++;
         end else begin
            want = expected_responses.pop_front();
            if (rsp_read_data !== want.read_data) begin
               $error("read_data: expected %h, got %h", want.read_data, rsp_read_data);
               failures++;
            end
            if (rsp_access_error !== want.access_error) begin
               $error("access_error: expected %b, got %b",
                      want.access_error, rsp_access_error);
               failures++;
            end
            if (rsp_supervisor_lines !== want.supervisor_lines) begin
               $error("supervisor_lines: expected %h, got %h",
                      want.supervisor_lines, rsp_supervisor_lines);
               failures++;
            end
            if (rsp_machine_lines !== want.machine_lines) begin
               $error("machine_lines: expected %h, got %h",
                      want.machine_lines, rsp_machine_lines);
               failures++;
            end
         end
      end
   end

   function automatic logic [OFFSET_W-1:0] context_offset(input int unsigned ctx,
                                                          input int unsigned word);
      return OFFSET_W'(CTX_BASE + ctx * CTX_STRIDE + word * 4);
   endfunction

   function automatic logic [OFFSET_W-1:0] enable_offset(input int unsigned ctx);
      return OFFSET_W'(EN_BASE + ctx * EN_STRIDE);
   endfunction

   task automatic send_transaction(input logic [CMD_W-1:0] command,
                                   input logic [OFFSET_W-1:0] offset,
                                   input logic [DATA_W-1:0] write_data,
                                   input logic [SRC_W-1:0] irq_source,
                                   input logic irq_level);
      request_type rq;
      rq = '{command, offset, write_data, irq_source, irq_level};
      req_command <= command;
      req_offset <= offset;
      req_write_data <= write_data;
      req_irq_source <= irq_source;
      req_irq_level <= irq_level;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      expected_responses.push_back(predict_response(rq));
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic wait_until_idle();
      int guard;
      guard = 0;
      start <= 1'b0;
      while (expected_responses.size() != 0 && guard < 2000) begin
         @(posedge clock);
         guard++;
      end
      repeat (6) @(posedge clock);
   endtask

   task automatic write_active_harts(input logic [HARTS_W-1:0] value);
      wait_until_idle();
      csr_write_data <= value;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      active_harts = value;
      csr_write_enable <= 1'b0;
   endtask

   task automatic test_priority_and_threshold();
      send_transaction(CMD_WRITE, OFFSET_W'(4 * 31), '1, 0, 0);
      send_transaction(CMD_READ, OFFSET_W'(4 * 31 + 3), '0, 0, 0);
      send_transaction(CMD_WRITE, 4, 32'hFFFF_FFF8, 0, 0);
      send_transaction(CMD_READ, 4, '0, 0, 0);
      send_transaction(CMD_WRITE, context_offset(0, CTX_WORD_THRESHOLD), 32'h5, 0, 0);
      send_transaction(CMD_READ, 0, '0, 0, 0);
      send_transaction(CMD_READ, context_offset(7, CTX_WORD_THRESHOLD), '0, 0, 0);
   endtask

   task automatic test_claim_and_complete();
      send_transaction(CMD_WRITE, enable_offset(0), '1, 0, 0);
      send_transaction(CMD_LEVEL, '0, '0, 0, 1);
      send_transaction(CMD_LEVEL, '0, '0, 1, 1);
      send_transaction(CMD_LEVEL, '0, '0, 31, 1);
      send_transaction(CMD_READ, PEND_BASE, '0, 0, 0);
      send_transaction(CMD_WRITE, OFFSET_W'(PEND_BASE + 3), '1, 0, 0);
      send_transaction(CMD_READ, context_offset(1, CTX_WORD_CLAIM), '0, 0, 0);
      send_transaction(CMD_READ, context_offset(6, CTX_WORD_CLAIM), '0, 0, 0);
      send_transaction(CMD_READ, context_offset(0, CTX_WORD_CLAIM), '0, 0, 0);
      send_transaction(CMD_WRITE, context_offset(2, CTX_WORD_CLAIM), 32'hFFFF_FFE1, 0, 0);
      send_transaction(CMD_WRITE, context_offset(0, CTX_WORD_CLAIM), 32'd31, 0, 0);
   endtask

   task automatic test_access_errors();
      send_transaction(CMD_READ, '1, '0, 0, 0);
      send_transaction(CMD_WRITE, OFFSET_W'(4 * DEF_NUM_SOURCES), '1, 0, 0);
      send_transaction(CMD_WRITE, context_offset(3, 2), '1, 0, 0);
      send_transaction(CMD_READ, context_offset(7, 10'h3FF), '0, 0, 0);
      send_transaction(CMD_UNUSED, '1, '1, '1, 1);
   endtask

   task automatic test_hart_limit();
      send_transaction(CMD_WRITE, enable_offset(2), '1, 0, 0);
      send_transaction(CMD_READ, enable_offset(2), '0, 0, 0);
      send_transaction(CMD_WRITE, OFFSET_W'(enable_offset(1) + 4), 32'h8000_0002, 0, 0);
   endtask

   function automatic request_type random_request();
      request_type rq;
      int unsigned pick, base;
      rq.command = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
      rq.offset = OFFSET_W'($urandom);
      rq.write_data = $urandom;
      rq.irq_source = SRC_W'($urandom);
      rq.irq_level = 1'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         rq.command = CMD_LEVEL;
         rq.irq_level = ($urandom_range(0, 9) < 7);
      end else if (pick < 45) begin
         rq.command = CMD_READ;
         rq.offset = OFFSET_W'(context_offset($urandom_range(0, 7), CTX_WORD_CLAIM)
                               + $urandom_range(0, 3));
      end else if (pick < 55) begin
         rq.command = CMD_WRITE;
         rq.offset = OFFSET_W'(context_offset($urandom_range(0, 7), CTX_WORD_CLAIM)
                               + $urandom_range(0, 3));
         if (claimed_mask != 0 && $urandom_range(0, 3) != 0) begin
            base = $urandom_range(0, 31);
            for (int k = 0; k < 32; k++) begin
               if (claimed_mask[(base + k) % 32]) begin
                  rq.write_data[SRC_W-1:0] = SRC_W'((base + k) % 32);
                  break;
               end
            end
         end
      end else if (pick < 65) begin
         rq.offset = OFFSET_W'(EN_BASE + $urandom_range(0, 2 * DEF_NUM_HARTS * EN_STRIDE - 1));
      end else if (pick < 75) begin
         rq.offset = OFFSET_W'($urandom_range(0, 4 * DEF_NUM_SOURCES - 1));
      end else if (pick < 80) begin
         rq.offset = OFFSET_W'(PEND_BASE + $urandom_range(0, 3));
      end else if (pick < 87) begin
         rq.offset = OFFSET_W'(CTX_BASE
                               + $urandom_range(0, 2 * DEF_NUM_HARTS * CTX_STRIDE - 1));
      end else if (pick < 90) begin
         rq.command = CMD_UNUSED;
      end
      return rq;
   endfunction

   task automatic test_random_traffic(input logic [HARTS_W-1:0] harts,
                                      input int idle_pct, input int count);
      request_type rq;
      write_active_harts(harts);
      sender_idle_pct = idle_pct;
      repeat (count) begin
         rq = random_request();
         send_transaction(rq.command, rq.offset, rq.write_data, rq.irq_source, rq.irq_level);
      end
      sender_idle_pct = 0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_priority_and_threshold();
      test_claim_and_complete();
      test_access_errors();
      test_hart_limit();
      test_random_traffic(3'd4, 0, 235);
      test_random_traffic(3'd4, 48, 235);
      test_random_traffic(3'd2, 27, 235);
      test_random_traffic(3'd1, 48, 235);
      test_random_traffic(3'd3, 0, 235);
      test_random_traffic(3'd0, 27, 235);
      test_random_traffic(3'd7, 48, 235);
      test_random_traffic(3'd4, 27, 235);
      wait_until_idle();
      if (expected_responses.size() != 0) begin
         $error("%0d transactions never got a response", expected_responses.size());
         failures++;
      end
      if (failures == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
